// ===== sv/lmse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmse_pkg
// Shared widths, defaults, constant tables and types of the logistic
// mean-squared-error engine.
// ----------------------------------------------------------------------------
package lmse_pkg;

    localparam int NUM_WEIGHTS_DEF   = 1024;
    localparam int MAX_POSITIONS_DEF = 1048576;

    localparam int IDX_W   = 10;
    localparam int WGT_W   = 16;
    localparam int COEF_W  = 16;
    localparam int RES_W   = 2;
    localparam int K_W     = 16;
    localparam int SCORE_W = 48;
    localparam int PROD_W  = 32;
    localparam int TOT_W   = 64;
    localparam int MEAN_W  = 32;
    localparam int CNT_W   = 21;
    localparam int P_W     = 33;
    localparam int DIVD_W  = 64;
    localparam int DIVS_W  = 34;
    localparam int S_W     = 17;
    localparam int SQ_W    = 33;

    localparam logic [K_W-1:0] SCALE_K_RST = 16'd4096;
    localparam logic [S_W-1:0] S_ONE       = 17'd65536;
    localparam logic [S_W-1:0] R_HALF      = 17'd32768;
    localparam logic [RES_W-1:0] RES_WIN   = 2'd2;
    localparam logic            OP_WRITE   = 1'b0;

    typedef struct packed {
        logic           done;
        logic           sat;
        logic           neg;
        logic [P_W-1:0] p;
    } t_pow_res;

    function automatic logic [15:0] pow_frac(input logic [2:0] i);
        logic [15:0] c;
        unique case (i)
            3'd0: c = 16'd46341;
            3'd1: c = 16'd55109;
            3'd2: c = 16'd60097;
            3'd3: c = 16'd62757;
            3'd4: c = 16'd64132;
            3'd5: c = 16'd64830;
            3'd6: c = 16'd65182;
            3'd7: c = 16'd65359;
            default: c = 16'd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/lmse_weight_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmse_weight_mem
// Weight table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lmse_weight_mem #(
    parameter int DEPTH = lmse_pkg::NUM_WEIGHTS_DEF,
    parameter int AW    = 10
) (
    input  wire                        i_clk,
    input  wire                        i_we,
    input  wire [AW-1:0]               i_waddr,
    input  wire [lmse_pkg::WGT_W-1:0]  i_wdata,
    input  wire [AW-1:0]               i_raddr,
    output logic [lmse_pkg::WGT_W-1:0] o_rdata
);

    logic [lmse_pkg::WGT_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== sv/lmse_pow2.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmse_pow2
// Forms p = 2^-(|k*score|/2^20) in Q1.32: three 16x16 partial products for
// the exponent, then one fraction bit per cycle, then the integer shift.
// ----------------------------------------------------------------------------
module lmse_pow2 (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [lmse_pkg::SCORE_W-1:0]  i_score,
    input  wire [lmse_pkg::K_W-1:0]      i_scale_k,
    output lmse_pkg::t_pow_res           o_res
);

    typedef enum logic [1:0] {P_IDLE, P_MUL, P_POW, P_SHIFT} t_state;

    t_state                         r_state;
    logic [2:0]                     r_step;
    logic [lmse_pkg::SCORE_W-1:0]   r_mag;
    logic [63:0]                    r_prod;
    logic [lmse_pkg::P_W-1:0]       r_p;
    logic                           r_neg;
    logic                           r_done;
    logic [15:0]                    mag_part;
    logic [31:0]                    part;
    logic [7:0]                     frac;
    logic [48:0]                    pmul;

    always_comb begin
        unique case (r_step[1:0])
            2'd0:    mag_part = r_mag[15:0];
            2'd1:    mag_part = r_mag[31:16];
            default: mag_part = r_mag[47:32];
        endcase
        part = mag_part * i_scale_k;
        frac = r_prod[19:12];
        pmul = r_p * lmse_pkg::pow_frac(r_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_score[lmse_pkg::SCORE_W-1];
                        r_mag   <= i_score[lmse_pkg::SCORE_W-1] ? -i_score : i_score;
                        r_prod  <= '0;
                        r_step  <= '0;
                        r_state <= P_MUL;
                    end
                end
                P_MUL: begin
                    unique case (r_step[1:0])
                        2'd0:    r_prod <= r_prod + 64'(part);
                        2'd1:    r_prod <= r_prod + {16'd0, part, 16'd0};
                        default: r_prod <= r_prod + {part, 32'd0};
                    endcase
                    if (r_step == 3'd2) begin
                        r_step  <= '0;
                        r_p     <= {1'b1, 32'd0};
                        r_state <= P_POW;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                P_POW: begin
                    if (frac[3'd7 - r_step]) begin
                        r_p <= pmul[48:16];
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= P_SHIFT;
                    end
                end
                P_SHIFT: begin
                    r_p     <= r_p >> r_prod[24:20];
                    r_done  <= 1'b1;
                    r_state <= P_IDLE;
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.sat  = |r_prod[63:25];
    assign o_res.neg  = r_neg;
    assign o_res.p    = r_p;

endmodule
`default_nettype wire

// ===== sv/lmse_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmse_divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// logistic and the mean.
// ----------------------------------------------------------------------------
module lmse_divider (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [lmse_pkg::DIVD_W-1:0]   i_dividend,
    input  wire [lmse_pkg::DIVS_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [lmse_pkg::DIVD_W-1:0]  o_quotient
);

    logic                          r_busy;
    logic [6:0]                    r_count;
    logic [lmse_pkg::DIVS_W-1:0]   r_div;
    logic [lmse_pkg::DIVS_W-1:0]   r_rem;
    logic [lmse_pkg::DIVS_W:0]     rem_sh;
    logic                          fits;

    always_comb begin
        rem_sh = {r_rem, o_quotient[lmse_pkg::DIVD_W-1]};
        fits   = rem_sh >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_done  <= 1'b0;
            r_count <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy     <= 1'b1;
                r_count    <= '0;
                r_div      <= i_divisor;
                r_rem      <= '0;
                o_quotient <= i_dividend;
            end else if (r_busy) begin
                r_rem <= fits ? lmse_pkg::DIVS_W'(rem_sh - {1'b0, r_div})
                              : lmse_pkg::DIVS_W'(rem_sh);
                o_quotient <= {o_quotient[lmse_pkg::DIVD_W-2:0], fits};
                r_count    <= r_count + 7'd1;
                if (r_count == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/logistic_mean_squared_error.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// logistic_mean_squared_error
// Weight table, coefficient-weight score, logistic error and set mean.
// ----------------------------------------------------------------------------
// One request at a time. A weight write goes straight into the table; a coefficient
// goes through a table read, a multiply and a saturating add. A position end then
// runs the exponent (3 partial products, 8 fraction steps, a shift and the
// hand-over), the 64-step radix-2 divider, then the square and the total; a
// saturated exponent skips the divider. A set end then forms the mean through
// the same divider (skipped for an empty set), plus any wait for the output
// register to drain. The scale register is written only while no request is
// in progress.
module logistic_mean_squared_error #(
    parameter int NUM_WEIGHTS   = lmse_pkg::NUM_WEIGHTS_DEF,
    parameter int MAX_POSITIONS = lmse_pkg::MAX_POSITIONS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire [0:0]                     i_in_op,
    input  wire [lmse_pkg::IDX_W-1:0]     i_in_index,
    input  wire signed [lmse_pkg::WGT_W-1:0]  i_in_weight_value,
    input  wire signed [lmse_pkg::COEF_W-1:0] i_in_coefficient,
    input  wire [lmse_pkg::RES_W-1:0]     i_in_game_result,
    input  wire                           i_in_last_of_position,
    input  wire                           i_in_last_of_set,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic [lmse_pkg::MEAN_W-1:0]   o_out_mean_error,
    output logic [lmse_pkg::CNT_W-1:0]    o_out_position_count,
    output logic                          o_out_empty_set,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [lmse_pkg::K_W-1:0]       i_cfg_data
);

    localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam int CW = $clog2(MAX_POSITIONS + 1);
    localparam int EW = 2*lmse_pkg::S_W+2;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_ACC, S_POW_GO, S_POW_WAIT, S_DIV_GO, S_DIV_WAIT,
        S_SQUARE, S_TOTAL, S_MEAN_GO, S_MEAN_WAIT, S_OUT
    } t_state;

    t_state                         r_state;
    logic [lmse_pkg::K_W-1:0]       r_scale_k;
    logic [lmse_pkg::COEF_W-1:0]    r_coef;
    logic [lmse_pkg::RES_W-1:0]     r_res;
    logic                           r_end_pos;
    logic                           r_end_set;
    logic                           r_in_range;
    logic [lmse_pkg::PROD_W-1:0]    r_prod;
    logic [lmse_pkg::SCORE_W-1:0]   r_score;
    logic [lmse_pkg::TOT_W-1:0]     r_total;
    logic [CW-1:0]                  r_count;
    logic [lmse_pkg::S_W-1:0]       r_s;
    logic [lmse_pkg::SQ_W-1:0]      r_sq;
    logic [lmse_pkg::MEAN_W-1:0]    r_mean;
    logic                           r_empty;

    logic                           accept;
    logic                           in_range;
    logic [AW-1:0]                  addr;
    logic [lmse_pkg::WGT_W-1:0]     rdata;
    logic [lmse_pkg::WGT_W-1:0]     weight;
    logic [lmse_pkg::SCORE_W:0]     sum;
    logic [lmse_pkg::SCORE_W-1:0]   sum_sat;
    lmse_pkg::t_pow_res             pow_res;
    logic                           div_start;
    logic [lmse_pkg::DIVD_W-1:0]    div_dividend;
    logic [lmse_pkg::DIVS_W-1:0]    div_divisor;
    logic                           div_done;
    logic [lmse_pkg::DIVD_W-1:0]    div_q;
    logic [lmse_pkg::DIVS_W-1:0]    den;
    logic [lmse_pkg::S_W-1:0]       target;
    logic signed [EW-1:0]           err;
    logic [EW-1:0]                  err_sq;
    logic                           out_free;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_range    = 32'(i_in_index) < NUM_WEIGHTS;
    assign addr        = AW'(32'(i_in_index));
    assign out_free    = !o_out_valid || !i_out_stall;

    lmse_weight_mem #(.DEPTH(NUM_WEIGHTS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (accept && (i_in_op == lmse_pkg::OP_WRITE) && in_range),
        .i_waddr (addr),
        .i_wdata (i_in_weight_value),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    lmse_pow2 u_pow (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_POW_GO),
        .i_score   (r_score),
        .i_scale_k (r_scale_k),
        .o_res     (pow_res)
    );

    lmse_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        weight  = r_in_range ? rdata : '0;
        sum     = {r_score[lmse_pkg::SCORE_W-1], r_score}
                + {{(lmse_pkg::SCORE_W-lmse_pkg::PROD_W+1){r_prod[lmse_pkg::PROD_W-1]}},
                   r_prod};
        if (sum[lmse_pkg::SCORE_W] != sum[lmse_pkg::SCORE_W-1]) begin
            sum_sat = sum[lmse_pkg::SCORE_W]
                    ? {1'b1, {(lmse_pkg::SCORE_W-1){1'b0}}}
                    : {1'b0, {(lmse_pkg::SCORE_W-1){1'b1}}};
        end else begin
            sum_sat = sum[lmse_pkg::SCORE_W-1:0];
        end
        den       = lmse_pkg::DIVS_W'(64'h1_0000_0000 + 64'(pow_res.p));
        div_start = (r_state == S_DIV_GO) || (r_state == S_MEAN_GO && r_count != '0);
        if (r_state == S_DIV_GO) begin
            div_dividend = 64'h1_0000_0000_0000 + 64'(den[lmse_pkg::DIVS_W-1:1]);
            div_divisor  = den;
        end else begin
            div_dividend = r_total + 64'(r_count >> 1);
            div_divisor  = lmse_pkg::DIVS_W'(r_count);
        end
        target = (r_res > lmse_pkg::RES_WIN) ? lmse_pkg::S_ONE
               : lmse_pkg::S_W'(r_res) * lmse_pkg::R_HALF;
        err    = EW'($signed({1'b0, target})) - EW'($signed({1'b0, r_s}));
        err_sq = $unsigned(err * err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale_k   <= lmse_pkg::SCALE_K_RST;
            r_score     <= '0;
            r_total     <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_scale_k <= i_cfg_data;
            end
            if (o_out_valid && !i_out_stall && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_in_op != lmse_pkg::OP_WRITE) begin
                        r_coef     <= i_in_coefficient;
                        r_res      <= i_in_game_result;
                        r_end_pos  <= i_in_last_of_position;
                        r_end_set  <= i_in_last_of_set;
                        r_in_range <= in_range;
                        r_state    <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_prod  <= $signed(r_coef) * $signed(weight);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_end_pos && !r_end_set) begin
                        r_score <= sum_sat;
                        r_state <= S_IDLE;
                    end else if (r_count < CW'(MAX_POSITIONS)) begin
                        r_score <= sum_sat;
                        r_state <= S_POW_GO;
                    end else begin
                        r_score <= '0;
                        r_state <= r_end_set ? S_MEAN_GO : S_IDLE;
                    end
                end
                S_POW_GO: r_state <= S_POW_WAIT;
                S_POW_WAIT: begin
                    if (pow_res.done) begin
                        if (pow_res.sat) begin
                            r_s     <= pow_res.neg ? '0 : lmse_pkg::S_ONE;
                            r_state <= S_SQUARE;
                        end else begin
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_s <= pow_res.neg ? lmse_pkg::S_ONE - div_q[lmse_pkg::S_W-1:0]
                                           : div_q[lmse_pkg::S_W-1:0];
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_sq    <= err_sq[lmse_pkg::SQ_W-1:0];
                    r_state <= S_TOTAL;
                end
                S_TOTAL: begin
                    r_total <= r_total + 64'(r_sq);
                    r_count <= r_count + CW'(1);
                    r_score <= '0;
                    r_state <= r_end_set ? S_MEAN_GO : S_IDLE;
                end
                S_MEAN_GO: begin
                    if (r_count == '0) begin
                        r_mean  <= '0;
                        r_empty <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_empty <= 1'b0;
                        r_state <= S_MEAN_WAIT;
                    end
                end
                S_MEAN_WAIT: begin
                    if (div_done) begin
                        r_mean  <= (|div_q[63:32]) ? '1 : div_q[31:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        o_out_valid          <= 1'b1;
                        o_out_mean_error     <= r_mean;
                        o_out_position_count <= lmse_pkg::CNT_W'(r_count);
                        o_out_empty_set      <= r_empty;
                        r_total              <= '0;
                        r_count              <= '0;
                        r_score              <= '0;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the logistic mean-squared-error engine: a directed
// table of weight writes and position/set requests, then random sets of
// positions under several logistic scales and idle/stall mixes, every set
// mean checked against the table's expected value or a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam logic       OP_COEF   = 1'b1;
    localparam logic [1:0] RES_LOSS  = 2'd0;
    localparam logic [1:0] RES_DRAW  = 2'd1;
    localparam logic [1:0] RES_THREE = 2'd3;
    localparam int         WDOG_LIMIT = 20000;
    localparam int         DRAIN_WAIT = 200;
    localparam longint     SCORE_MAX = 64'sd140737488355327;
    localparam longint     SCORE_MIN = -SCORE_MAX - 1;
    localparam longint unsigned FRAC_C [8] = '{46341, 55109, 60097, 62757,
                                               64132, 64830, 65182, 65359};

    typedef struct {
        logic                        op;
        logic [lmse_pkg::IDX_W-1:0]  idx;
        logic [lmse_pkg::WGT_W-1:0]  wv;
        logic [lmse_pkg::COEF_W-1:0] coef;
        logic [lmse_pkg::RES_W-1:0]  res;
        logic                        lp;
        logic                        ls;
        logic                        typed;
        logic [lmse_pkg::MEAN_W-1:0] mean;
        logic [lmse_pkg::CNT_W-1:0]  cnt;
        logic                        empty;
    } request_t;

    typedef struct {
        logic [lmse_pkg::MEAN_W-1:0] mean;
        logic [lmse_pkg::CNT_W-1:0]  cnt;
        logic                        empty;
    } set_mean_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [0:0] i_in_op = '0;
    logic [lmse_pkg::IDX_W-1:0] i_in_index = '0;
    logic [lmse_pkg::WGT_W-1:0] i_in_weight_value = '0;
    logic [lmse_pkg::COEF_W-1:0] i_in_coefficient = '0;
    logic [lmse_pkg::RES_W-1:0] i_in_game_result = '0;
    logic i_in_last_of_position = 1'b0;
    logic i_in_last_of_set = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [lmse_pkg::MEAN_W-1:0] o_out_mean_error;
    logic [lmse_pkg::CNT_W-1:0] o_out_position_count;
    logic o_out_empty_set;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [lmse_pkg::K_W-1:0] i_cfg_data = '0;

    logistic_mean_squared_error DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [lmse_pkg::WGT_W-1:0] weights [lmse_pkg::NUM_WEIGHTS_DEF];
    longint                    score_acc;
    longint unsigned           err_total;
    int unsigned               pos_seen;
    logic [lmse_pkg::K_W-1:0]  scale_k;

    set_mean_t   mean_q [$];
    int          written_idx [$];
    request_t    dir_rows [$];
    int          errors, items, results, settings;
    int          idle_pct, stall_pct, wdog;
    logic        in_acc, out_acc, cfg_acc;

    function automatic longint unsigned sigmoid_q16(input longint score);
        longint unsigned mag, x8, n, p, d, sp;
        logic neg;
        neg = score < 0;
        mag = neg ? longint'(-score) : score;
        x8 = (mag * longint'(scale_k)) >> 12;
        n = x8 >> 8;
        if (n >= 32) return neg ? 64'd0 : 64'd65536;
        p = 64'h1_0000_0000;
        for (int i = 0; i < 8; i++)
            if (x8[7-i]) p = (p * FRAC_C[i]) >> 16;
        p = p >> n;
        d = 64'h1_0000_0000 + p;
        sp = (64'h1_0000_0000_0000 + (d >> 1)) / d;
        return neg ? 64'd65536 - sp : sp;
    endfunction

    function automatic logic predict_set_mean(input request_t r, output set_mean_t m);
        longint acc, e, tgt;
        longint unsigned mean;
        m = '{default: '0};
        if (r.op == lmse_pkg::OP_WRITE) begin
            weights[r.idx] = r.wv;
            return 1'b0;
        end
        acc = score_acc + longint'($signed(r.coef)) * longint'(weights[r.idx]);
        if (acc > SCORE_MAX) acc = SCORE_MAX;
        if (acc < SCORE_MIN) acc = SCORE_MIN;
        score_acc = acc;
        if (!r.lp && !r.ls) return 1'b0;
        if (pos_seen < lmse_pkg::MAX_POSITIONS_DEF) begin
            tgt = (r.res >= lmse_pkg::RES_WIN) ? 64'sd65536 : longint'(r.res) * 64'sd32768;
            e = tgt - longint'(sigmoid_q16(score_acc));
            err_total += longint'(e * e);
            pos_seen++;
        end
        score_acc = 0;
        if (!r.ls) return 1'b0;
        if (pos_seen == 0) begin
            m.empty = 1'b1;
        end else begin
            mean = (err_total + (pos_seen >> 1)) / pos_seen;
            m.mean = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
            m.cnt = pos_seen[lmse_pkg::CNT_W-1:0];
        end
        err_total = 0;
        pos_seen = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        in_acc  = i_in_valid && !o_in_stall;
        out_acc = o_out_valid && !i_out_stall;
        cfg_acc = i_cfg_valid && o_cfg_ready;
        if (out_acc) begin
            if (mean_q.size() == 0) begin
                report_mismatch("unexpected result", o_out_mean_error, -1);
            end else begin
                set_mean_t m;
                m = mean_q.pop_front();
                results++;
                if (o_out_mean_error !== m.mean)
                    report_mismatch("mean_error", o_out_mean_error, m.mean);
                if (o_out_position_count !== m.cnt)
                    report_mismatch("position_count", o_out_position_count, m.cnt);
                if (o_out_empty_set !== m.empty)
                    report_mismatch("empty_set", o_out_empty_set, m.empty);
            end
        end
        if (!i_rst_n || in_acc || out_acc || cfg_acc) wdog = 0;
        else wdog++;
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_stall = ($urandom_range(99) < stall_pct);

    task automatic send(input request_t r);
        set_mean_t m;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_op = r.op;
        i_in_index = r.idx;
        i_in_weight_value = r.wv;
        i_in_coefficient = r.coef;
        i_in_game_result = r.res;
        i_in_last_of_position = r.lp;
        i_in_last_of_set = r.ls;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        items++;
        if (r.op == lmse_pkg::OP_WRITE) written_idx.push_back(int'(r.idx));
        if (predict_set_mean(r, m))
            mean_q.push_back(r.typed ? set_mean_t'{r.mean, r.cnt, r.empty} : m);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (mean_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_scale(input logic [lmse_pkg::K_W-1:0] k);
        drain();
        i_cfg_data = k;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        scale_k = k;
        settings++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic request_t mk(input logic op, input int idx, input int wv, input int coef,
                                    input logic [1:0] res, input logic lp, input logic ls);
        request_t r;
        r = '{default: '0};
        r.op = op;
        r.idx = lmse_pkg::IDX_W'(idx);
        r.wv = lmse_pkg::WGT_W'(wv);
        r.coef = lmse_pkg::COEF_W'(coef);
        r.res = res; r.lp = lp; r.ls = ls;
        return r;
    endfunction

    function automatic request_t typed_row(input request_t r, input logic [31:0] mean,
                                           input int cnt);
        r.typed = 1'b1; r.mean = mean; r.cnt = lmse_pkg::CNT_W'(cnt);
        return r;
    endfunction

    function automatic int rand_val();
        return $urandom_range(1) ? int'($urandom_range(127)) - 64
                                 : int'($urandom_range(65535)) - 32768;
    endfunction

    task automatic random_phase(input int n);
        int npos, ncoef, start;
        logic pause_done;
        request_t r;
        pause_done = 1'b0;
        repeat (32) send(mk(OP_WRITE_C(), int'($urandom_range(1023)), rand_val(), 0,
                            2'd0, 1'b0, 1'b0));
        start = items;
        while (items - start < n) begin
            if ($urandom_range(9) == 0) begin
                r = mk(OP_WRITE_C(), int'($urandom_range(1023)), rand_val(), int'($urandom),
                       2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
                send(r);
                continue;
            end
            npos = $urandom_range(1, 4);
            for (int p = 0; p < npos; p++) begin
                ncoef = $urandom_range(1, 4);
                for (int c = 0; c < ncoef; c++) begin
                    r = mk(OP_COEF, written_idx[$urandom_range(written_idx.size() - 1)],
                           int'($urandom), rand_val(), 2'($urandom_range(3)), 1'b0, 1'b0);
                    if (c == ncoef - 1) begin
                        r.ls = (p == npos - 1);
                        r.lp = r.ls ? 1'($urandom_range(1)) : 1'b1;
                    end
                    send(r);
                end
            end
            if (!pause_done) begin
                while (mean_q.size() != 0) @(negedge i_clk);
                pause_done = 1'b1;
            end
        end
    endtask

    function automatic logic OP_WRITE_C();
        return lmse_pkg::OP_WRITE;
    endfunction

    initial begin
        int idle_tab [4];
        int stall_tab [4];
        idle_tab = '{0, 65, 0, 32};
        stall_tab = '{0, 0, 65, 32};
        errors = 0; items = 0; results = 0; settings = 0; wdog = 0;
        idle_pct = 0; stall_pct = 0;
        score_acc = 0; err_total = 0; pos_seen = 0; scale_k = lmse_pkg::SCALE_K_RST;
        foreach (weights[i]) weights[i] = '0;

        dir_rows.push_back(mk(lmse_pkg::OP_WRITE, 0, 0, 0, RES_LOSS, 1'b0, 1'b0));
        dir_rows.push_back(mk(lmse_pkg::OP_WRITE, 1023, 32767, 0, RES_LOSS, 1'b0, 1'b0));
        dir_rows.push_back(mk(lmse_pkg::OP_WRITE, 512, -32768, 0, RES_THREE, 1'b1, 1'b1));
        dir_rows.push_back(typed_row(mk(OP_COEF, 0, 0, 100, RES_DRAW, 1'b1, 1'b1), 0, 1));
        dir_rows.push_back(typed_row(mk(OP_COEF, 0, 0, -1, lmse_pkg::RES_WIN, 1'b0, 1'b1),
                                     32'h4000_0000, 1));
        dir_rows.push_back(typed_row(mk(OP_COEF, 0, 0, 1, RES_LOSS, 1'b1, 1'b1),
                                     32'h4000_0000, 1));
        dir_rows.push_back(typed_row(mk(OP_COEF, 1023, 0, 32767, RES_LOSS, 1'b1, 1'b1),
                                     32'hFFFF_FFFF, 1));
        dir_rows.push_back(typed_row(mk(OP_COEF, 1023, 0, 32767, lmse_pkg::RES_WIN,
                                        1'b1, 1'b1), 0, 1));
        dir_rows.push_back(typed_row(mk(OP_COEF, 1023, 0, -32768, RES_LOSS, 1'b1, 1'b1),
                                     0, 1));
        dir_rows.push_back(typed_row(mk(OP_COEF, 1023, 0, -32768, RES_THREE, 1'b1, 1'b1),
                                     32'hFFFF_FFFF, 1));
        dir_rows.push_back(mk(lmse_pkg::OP_WRITE, 5, 3, 0, RES_LOSS, 1'b0, 1'b0));
        dir_rows.push_back(mk(OP_COEF, 5, 0, 256, RES_DRAW, 1'b1, 1'b0));
        dir_rows.push_back(mk(OP_COEF, 512, 0, 1, lmse_pkg::RES_WIN, 1'b0, 1'b0));
        dir_rows.push_back(mk(OP_COEF, 5, 0, -300, RES_LOSS, 1'b1, 1'b0));
        dir_rows.push_back(mk(OP_COEF, 0, 0, 7, lmse_pkg::RES_WIN, 1'b0, 1'b1));
        dir_rows.push_back(mk(OP_COEF, 512, 0, 32767, RES_THREE, 1'b1, 1'b1));

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) send(dir_rows[i]);

        for (int ph = 0; ph < 8; ph++) begin
            idle_pct = 0;
            stall_pct = 0;
            write_scale(ph == 0 ? 16'd0 : ph == 1 ? 16'd40960 : ph == 2 ? lmse_pkg::SCALE_K_RST
                        : lmse_pkg::K_W'($urandom_range(40960)));
            idle_pct = idle_tab[ph % 4];
            stall_pct = stall_tab[ph % 4];
            random_phase(115);
        end

        idle_pct = 0;
        while (mean_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        $display("covered %0d requests, %0d set means, %0d scale settings", items, results,
                 settings + 1);
        $display("mixes: no idling, sender idle, receiver stalls, both; %0d mismatches",
                 errors);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
